### rtl/firdf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package firdf_pkg;

  // filter length in use, and the number of coefficient registers held
  localparam int TAPS      = 8;
  localparam int NUM_COEF  = 8;

  localparam int SAMPLE_W  = 16;
  localparam int COEF_W    = 16;
  localparam int COEF_IW   = $clog2(NUM_COEF);
  localparam int TAP_W     = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int PROD_W    = SAMPLE_W + COEF_W;
  // one guard bit above the sum of TAPS products, plus the sign
  localparam int ACC_W     = PROD_W + 1 + $clog2(TAPS);
  localparam int FRAC_W    = 15;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic start;
    logic mac;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic last_tap;
  } status_t;

endpackage

`default_nettype wire

### rtl/fir_filter_direct_form_top.sv
// channel  direction  handshake                  payload
// in       input      in_valid_i / in_stall_o    sample_in_i
// out      output     out_valid_o / out_stall_i  sample_out_o, saturated_o
// cfg      input      cfg_we_i                   cfg_index_i, cfg_data_i
//
// one transaction at a time: the input stalls until the result is loaded.
// the single multiplier steps through one tap per cycle, followed by the
// product register and the output load.
// a finished result sits in the output register; the next sample is taken
// while it waits, and only the final load waits on a stalled output.
// reset clears the delay line and coefficients to zero.
`timescale 1ns / 1ps
`default_nettype none

module fir_filter_direct_form_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  firdf_pkg::sample_t             sample_in_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output firdf_pkg::sample_t             sample_out_o,
  output logic                           saturated_o,
  input  logic                           cfg_we_i,
  input  logic [firdf_pkg::COEF_IW-1:0]  cfg_index_i,
  input  logic [firdf_pkg::COEF_W-1:0]   cfg_data_i
);
  import firdf_pkg::*;

  cmd_t    cmd;
  status_t status;

  firdf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  firdf_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .sample_in_i  (sample_in_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .sample_out_o (sample_out_o),
    .saturated_o  (saturated_o)
  );

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken again right after a transaction");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> (!out_valid_o || !out_stall_i))
    else $error("held result overwritten");

  a_sat_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && saturated_o) |->
      (sample_out_o == 16'sh7fff || sample_out_o == 16'sh8000))
    else $error("saturation flag without a clipped value");
`endif

endmodule

`default_nettype wire

### rtl/firdf_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module firdf_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  firdf_pkg::cmd_t                cmd_i,
  output firdf_pkg::status_t             status_o,
  input  firdf_pkg::sample_t             sample_in_i,
  input  logic                           cfg_we_i,
  input  logic [firdf_pkg::COEF_IW-1:0]  cfg_index_i,
  input  logic [firdf_pkg::COEF_W-1:0]   cfg_data_i,
  output firdf_pkg::sample_t             sample_out_o,
  output logic                           saturated_o
);
  import firdf_pkg::*;

  sample_t                   dl_q [TAPS];
  coef_t                     coef_q [NUM_COEF];
  logic [TAP_W-1:0]          tap_q;
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [PROD_W-1:0]  prod_d;
  logic                      prod_vld_q;
  logic signed [ACC_W-1:0]   acc_q;
  logic signed [ACC_W-1:0]   rnd;
  logic                      sat_pos;
  logic                      sat_neg;
  sample_t                   res_d;
  sample_t                   sample_out_q;
  logic                      sat_q;
  sample_t                   sel_dl;
  coef_t                     sel_coef;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_COEF; i++) coef_q[i] <= '0;
    end else if (cfg_we_i) begin
      coef_q[cfg_index_i] <= cfg_data_i;
    end
  end

  // newest sample lands in entry 0
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TAPS; i++) dl_q[i] <= '0;
    end else if (cmd_i.start) begin
      for (int i = TAPS - 1; i > 0; i--) dl_q[i] <= dl_q[i-1];
      dl_q[0] <= sample_in_i;
    end
  end

  assign sel_dl   = dl_q[tap_q];
  assign sel_coef = coef_q[COEF_IW'(tap_q)];
  assign prod_d   = PROD_W'(sel_dl) * PROD_W'(sel_coef);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_q      <= '0;
      prod_vld_q <= 1'b0;
    end else begin
      prod_vld_q <= cmd_i.mac;
      if (cmd_i.start) begin
        tap_q <= '0;
      end else if (cmd_i.mac) begin
        tap_q <= tap_q + TAP_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mac) begin
      prod_q <= prod_d;
    end
    if (cmd_i.start) begin
      acc_q <= '0;
    end else if (prod_vld_q) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
  end

  assign status_o.last_tap = (tap_q == TAP_W'(TAPS - 1));

  // round half up, then clip when the bits above the q1.15 range disagree
  assign rnd     = acc_q + ACC_W'(1 << (FRAC_W - 1));
  assign sat_pos = !rnd[ACC_W-1] && (|rnd[ACC_W-2:2*FRAC_W]);
  assign sat_neg = rnd[ACC_W-1] && !(&rnd[ACC_W-2:2*FRAC_W]);

  always_comb begin
    if (sat_pos) begin
      res_d = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else if (sat_neg) begin
      res_d = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      res_d = rnd[2*FRAC_W:FRAC_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      sample_out_q <= res_d;
      sat_q        <= sat_pos | sat_neg;
    end
  end

  assign sample_out_o = sample_out_q;
  assign saturated_o  = sat_q;

endmodule

`default_nettype wire

### rtl/firdf_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module firdf_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  firdf_pkg::status_t  status_i,
  output firdf_pkg::cmd_t     cmd_o
);
  import firdf_pkg::*;

  state_e state_q;
  state_e state_d;
  logic   out_valid_q;
  logic   out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_MAC;
      ST_MAC:   if (status_i.last_tap) state_d = ST_DRAIN;
      ST_DRAIN: state_d = ST_DONE;
      ST_DONE:  if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o  = 1'b0;
        cmd_o.start = in_valid_i;
      end
      ST_MAC: begin
        cmd_o.mac = 1'b1;
      end
      ST_DRAIN: begin
      end
      ST_DONE: begin
        cmd_o.load_out = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

### verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import firdf_pkg::*;

  // clean block latency plus a little slack
  localparam int SETTLE_CYCLES = TAPS + 3 + 4;
  localparam int N_DIRECTED = 21;
  localparam int N_PHASES = 10;
  localparam int PHASE_ITEMS = 110;

  // preset coefficient sets used by the directed rows
  localparam int CSET_ZERO = 0;
  localparam int CSET_HALF_TAP0 = 1;
  localparam int CSET_ALL_MIN = 2;
  localparam int CSET_ALL_MAX = 3;

  // coefficient mixes for the random phases
  localparam int CMIX_FULL = 0;
  localparam int CMIX_MAX = 1;
  localparam int CMIX_MIN = 2;
  localparam int CMIX_SMALL = 3;
  localparam int CMIX_ONE_TAP = 4;
  localparam int CMIX_EXTREME = 5;

  typedef struct packed {
    int      coef_set;
    sample_t sample;
    bit      typed;
    sample_t y;
    logic    sat;
  } dir_row_t;

  typedef struct {
    sample_t y;
    logic    sat;
  } filt_t;

  localparam dir_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    '{CSET_ZERO,      16'h7FFF, 1'b1, 16'h0000, 1'b0},
    '{CSET_ZERO,      16'h8000, 1'b1, 16'h0000, 1'b0},
    '{CSET_ZERO,      16'h5555, 1'b1, 16'h0000, 1'b0},
    '{CSET_ZERO,      16'h2AAA, 1'b1, 16'h0000, 1'b0},
    // half-way ties round up, also for negative sums
    '{CSET_HALF_TAP0, 16'h0001, 1'b1, 16'h0001, 1'b0},
    '{CSET_HALF_TAP0, 16'hFFFF, 1'b1, 16'h0000, 1'b0},
    '{CSET_HALF_TAP0, 16'h0003, 1'b1, 16'h0002, 1'b0},
    '{CSET_HALF_TAP0, 16'h7FFF, 1'b1, 16'h4000, 1'b0},
    '{CSET_HALF_TAP0, 16'h8000, 1'b1, 16'hC000, 1'b0},
    // fill the line with the most negative sample against the most negative coefs
    '{CSET_ALL_MIN,   16'h8000, 1'b0, 16'h0000, 1'b0},
    '{CSET_ALL_MIN,   16'h8000, 1'b0, 16'h0000, 1'b0},
    '{CSET_ALL_MIN,   16'h8000, 1'b0, 16'h0000, 1'b0},
    '{CSET_ALL_MIN,   16'h8000, 1'b0, 16'h0000, 1'b0},
    '{CSET_ALL_MIN,   16'h8000, 1'b0, 16'h0000, 1'b0},
    '{CSET_ALL_MIN,   16'h8000, 1'b0, 16'h0000, 1'b0},
    '{CSET_ALL_MIN,   16'h8000, 1'b0, 16'h0000, 1'b0},
    '{CSET_ALL_MIN,   16'h8000, 1'b1, 16'h7FFF, 1'b1},
    '{CSET_ALL_MAX,   16'h8000, 1'b1, 16'h8000, 1'b1},
    '{CSET_ALL_MAX,   16'h8000, 1'b1, 16'h8000, 1'b1},
    '{CSET_ALL_MAX,   16'h7FFF, 1'b0, 16'h0000, 1'b0},
    '{CSET_ZERO,      16'h1234, 1'b1, 16'h0000, 1'b0}
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  sample_t sample_in_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  sample_t sample_out_o;
  logic saturated_o;
  logic cfg_we_i = 1'b0;
  logic [COEF_IW-1:0] cfg_index_i = '0;
  logic [COEF_W-1:0] cfg_data_i = '0;

  sample_t delay_hist [TAPS] = '{default: '0};
  coef_t coef_shadow [NUM_COEF] = '{default: '0};
  filt_t filtered_q [$];
  int err_count = 0;
  bit tx_idle_en = 1'b1;
  bit rx_idle_en = 1'b1;
  int stall_left = 0;

  fir_filter_direct_form_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .sample_in_i  (sample_in_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .sample_out_o (sample_out_o),
    .saturated_o  (saturated_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    #1_000_000;
    $display("Verification failed");
    $finish;
  end

  // shift the new sample in, then round and clip the weighted sum
  function automatic void shift_and_filter(input sample_t s, output sample_t y,
                                           output logic sat);
    longint acc;
    longint r;
    int k;
    for (k = TAPS - 1; k > 0; k--) delay_hist[k] = delay_hist[k-1];
    delay_hist[0] = s;
    acc = 0;
    for (k = 0; k < TAPS; k++) acc += longint'(delay_hist[k]) * longint'(coef_shadow[k]);
    r = acc + 16384;
    if (r >= (longint'(1) << 30)) begin
      y = 16'sh7FFF;
      sat = 1'b1;
    end else if (r < -(longint'(1) << 30)) begin
      y = 16'sh8000;
      sat = 1'b1;
    end else begin
      y = sample_t'(r >>> 15);
      sat = 1'b0;
    end
  endfunction

  function automatic coef_t preset_coef(int set, int k);
    case (set)
      CSET_HALF_TAP0: return (k == 0) ? 16'sh4000 : 16'sh0000;
      CSET_ALL_MIN:   return 16'sh8000;
      CSET_ALL_MAX:   return 16'sh7FFF;
      default:        return 16'sh0000;
    endcase
  endfunction

  function automatic coef_t rand_coef(int mix);
    case (mix)
      CMIX_MAX:     return 16'sh7FFF;
      CMIX_MIN:     return 16'sh8000;
      CMIX_SMALL:   return coef_t'($urandom_range(0, 8192)) - 16'sd4096;
      CMIX_EXTREME: begin
        case ($urandom_range(0, 3))
          0:       return 16'sh7FFF;
          1:       return 16'sh8000;
          2:       return 16'sh0000;
          default: return coef_t'($urandom);
        endcase
      end
      default:      return coef_t'($urandom);
    endcase
  endfunction

  function automatic sample_t rand_sample();
    case ($urandom_range(0, 7))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return sample_t'($urandom_range(0, 16)) - 16'sd8;
      default: return sample_t'($urandom);
    endcase
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    err_count++;
  endtask

  // one input transaction; a typed row overrides the predicted result
  task automatic send(input sample_t s, input bit typed, input sample_t ty, input logic tsat);
    sample_t py;
    logic psat;
    if (tx_idle_en && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_in_i <= s;
    do @(posedge clk_i); while (in_stall_o);
    shift_and_filter(s, py, psat);
    if (typed) filtered_q.push_back('{ty, tsat});
    else filtered_q.push_back('{py, psat});
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (filtered_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic load_coefs(input coef_t c [NUM_COEF]);
    int k;
    for (k = 0; k < NUM_COEF; k++) begin
      @(posedge clk_i);
      cfg_we_i <= 1'b1;
      cfg_index_i <= k[COEF_IW-1:0];
      cfg_data_i <= c[k];
      coef_shadow[k] = c[k];
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // receiver stall comes in bursts, off entirely when idling is disabled
  always @(posedge clk_i) begin
    if (!rx_idle_en) begin
      out_stall_i <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else begin
      out_stall_i <= ($urandom_range(0, 2) == 0);
      stall_left <= $urandom_range(0, 11);
    end
  end

  always @(posedge clk_i) begin
    filt_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (filtered_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected transaction out=%0d sat=%0b",
                                sample_out_o, saturated_o));
      end else begin
        want = filtered_q.pop_front();
        if (sample_out_o !== want.y)
          flag_mismatch($sformatf("sample_out got %0d want %0d", sample_out_o, want.y));
        if (saturated_o !== want.sat)
          flag_mismatch($sformatf("saturated got %0b want %0b", saturated_o, want.sat));
      end
    end
  end

  initial begin
    int i;
    int k;
    int p;
    int n;
    int cur_set;
    int mix;
    int hot;
    coef_t cs [NUM_COEF];

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    cur_set = CSET_ZERO;
    for (i = 0; i < N_DIRECTED; i++) begin
      if (DIRECTED_ROWS[i].coef_set != cur_set) begin
        wait_idle();
        cur_set = DIRECTED_ROWS[i].coef_set;
        for (k = 0; k < NUM_COEF; k++) cs[k] = preset_coef(cur_set, k);
        load_coefs(cs);
      end
      send(DIRECTED_ROWS[i].sample, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].y,
           DIRECTED_ROWS[i].sat);
    end

    for (p = 0; p < N_PHASES; p++) begin
      tx_idle_en = (p != N_PHASES - 1) && ($urandom_range(0, 3) != 0);
      rx_idle_en = (p != N_PHASES - 1) && ($urandom_range(0, 3) != 0);
      mix = $urandom_range(CMIX_FULL, CMIX_EXTREME);
      hot = $urandom_range(0, NUM_COEF - 1);
      for (k = 0; k < NUM_COEF; k++)
        cs[k] = (mix == CMIX_ONE_TAP && k != hot) ? 16'sh0000 : rand_coef(mix);
      wait_idle();
      load_coefs(cs);
      for (n = 0; n < PHASE_ITEMS; n++) send(rand_sample(), 1'b0, '0, 1'b0);
    end

    wait_idle();
    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/firdf_pkg.sv
rtl/firdf_datapath.sv
rtl/firdf_ctrl.sv
rtl/fir_filter_direct_form_top.sv
verif/testbench.sv
